// ===== design/tagrp_pkg.sv =====
// Shared types, constants and header tables for the tagged record parser.
package tagrp_pkg;

    localparam int STORE_DEPTH          = 9;
    localparam int STORE_AW             = $clog2(STORE_DEPTH);
    localparam int CNT_W                = $clog2(STORE_DEPTH + 1);
    localparam int NAME_CAPACITY_DEF    = 9;
    localparam int SEX_CAPACITY_DEF     = 7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_X     = 8'h58;

    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_AGE  = 2'd1,
        KIND_SEX  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_HEADER,
        ST_TEXT,
        ST_EOL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } t_mem_req;

    function automatic logic [7:0] hdr_char(t_kind kind, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (kind)
            KIND_NAME: begin
                case (pos)
                    3'd0:    ch = CH_N;
                    3'd1:    ch = CH_A;
                    3'd2:    ch = CH_M;
                    3'd3:    ch = CH_E;
                    3'd4:    ch = CH_COLON;
                    default: ch = 8'h00;
                endcase
            end
            KIND_AGE: begin
                case (pos)
                    3'd0:    ch = CH_A;
                    3'd1:    ch = CH_G;
                    3'd2:    ch = CH_E;
                    3'd3:    ch = CH_COLON;
                    default: ch = 8'h00;
                endcase
            end
            KIND_SEX: begin
                case (pos)
                    3'd0:    ch = CH_S;
                    3'd1:    ch = CH_E;
                    3'd2:    ch = CH_X;
                    3'd3:    ch = CH_COLON;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] hdr_len(t_kind kind);
        logic [2:0] len;
        case (kind)
            KIND_NAME: len = 3'd5;
            KIND_AGE:  len = 3'd4;
            KIND_SEX:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== design/tagrp_text_mem.sv =====
// Text store: one write port and one registered read port.
module tagrp_text_mem (
    input  logic                i_clk,
    input  tagrp_pkg::t_mem_req i_req,
    output logic [7:0]          o_rdata
);
    import tagrp_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

// ===== design/tagged_record_serial_parser_unit.sv =====
// Usage: the input channel takes one received byte per item (i_in_valid/o_in_ready).
// Bytes are parsed as "NAME:", "AGE:" or "SEX:" headers followed by text up to a
// carriage return; the record is emitted when the following line feed arrives.
// Every byte outside record emission is taken when offered and updates the parse
// state; name and sex text bytes, up to the capacity, go into the text store memory.
// On the closing line feed the block enters emission and holds o_in_ready low.
// A record with n stored bytes is read out of the store one entry per cycle while
// the receiver takes results, each entry passing the memory read register; an age
// record or an empty record gives a single result.
// Each result sits in an output register (o_out_valid/i_out_ready); when the
// receiver stalls, the read sequencer waits with the next entry held in the
// memory read register, and input stays blocked until the last result is
// loaded. The line feed itself is accepted regardless of the output side.
// Reset (i_rst_n low, synchronous) returns the parser to waiting for a header
// and empties the output register; the text store is not cleared, since only
// entries written in the current record are ever read.
module tagged_record_serial_parser_unit #(
    parameter int NAME_CAPACITY = tagrp_pkg::NAME_CAPACITY_DEF,
    parameter int SEX_CAPACITY  = tagrp_pkg::SEX_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_record_kind,
    output logic       o_has_char,
    output logic [3:0] o_char_pos,
    output logic [7:0] o_char_value,
    output logic [3:0] o_text_length,
    output logic [7:0] o_age_value,
    output logic       o_last
);
    import tagrp_pkg::*;

    localparam int NAME_CAP_INT = (NAME_CAPACITY > STORE_DEPTH) ? STORE_DEPTH : NAME_CAPACITY;
    localparam int SEX_CAP_INT  = (SEX_CAPACITY > STORE_DEPTH) ? STORE_DEPTH : SEX_CAPACITY;
    localparam logic [CNT_W-1:0] NAME_CAP = CNT_W'(NAME_CAP_INT);
    localparam logic [CNT_W-1:0] SEX_CAP  = CNT_W'(SEX_CAP_INT);

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [2:0]          r_hdr_pos, n_hdr_pos;
    logic [CNT_W-1:0]    r_write_pos, n_write_pos;
    logic [7:0]          r_age, n_age;
    logic [CNT_W-1:0]    r_issue_idx, n_issue_idx;
    logic [STORE_AW-1:0] r_data_pos, n_data_pos;
    logic                r_rd_pend, n_rd_pend;

    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_kind, n_out_kind;
    logic                r_out_has, n_out_has;
    logic [3:0]          r_out_pos, n_out_pos;
    logic [7:0]          r_out_char, n_out_char;
    logic [3:0]          r_out_len, n_out_len;
    logic [7:0]          r_out_age, n_out_age;
    logic                r_out_last, n_out_last;

    t_mem_req            mem_req;
    logic [7:0]          mem_rdata;

    logic                in_take;
    logic                hdr_match;
    logic                hdr_done;
    logic                is_start;
    logic                is_digit;
    logic [CNT_W-1:0]    cap;
    logic                single;
    logic                slot_free;
    logic                load;
    logic                issue;
    logic                data_last;
    logic [7:0]          age_next;

    tagrp_text_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready = (r_state != ST_EMIT);
    assign in_take    = i_in_valid && o_in_ready;

    assign is_start  = (i_rx_byte == CH_N) || (i_rx_byte == CH_A) || (i_rx_byte == CH_S);
    assign hdr_match = (r_hdr_pos < hdr_len(r_kind)) && (i_rx_byte == hdr_char(r_kind, r_hdr_pos));
    assign hdr_done  = (3'(r_hdr_pos + 3'd1) >= hdr_len(r_kind));
    assign is_digit  = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign cap       = (r_kind == KIND_NAME) ? NAME_CAP : SEX_CAP;
    // age * 10 + digit, wrapping at 8 bits.
    assign age_next  = {r_age[4:0], 3'b000} + {r_age[6:0], 1'b0} + (i_rx_byte - CH_ZERO);

    assign single    = (r_kind == KIND_AGE) || (r_write_pos == '0);
    assign slot_free = !r_out_valid || i_out_ready;
    assign data_last = (CNT_W'(r_data_pos) + CNT_W'(1)) == r_write_pos;
    assign load      = (r_state == ST_EMIT) && slot_free && (single || r_rd_pend);
    assign issue     = (r_state == ST_EMIT) && !single && (r_issue_idx < r_write_pos)
                       && (!r_rd_pend || load);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_WAIT: begin
                if (in_take && is_start) begin
                    n_state = ST_HEADER;
                end
            end
            ST_HEADER: begin
                if (in_take) begin
                    if (!hdr_match) begin
                        n_state = ST_WAIT;
                    end else if (hdr_done) begin
                        n_state = ST_TEXT;
                    end
                end
            end
            ST_TEXT: begin
                if (in_take && (i_rx_byte == CH_CR)) begin
                    n_state = ST_EOL;
                end
            end
            ST_EOL: begin
                if (in_take && (i_rx_byte == CH_LF)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && (single || data_last)) begin
                    n_state = ST_WAIT;
                end
            end
            default: n_state = ST_WAIT;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_kind        = r_kind;
        n_hdr_pos     = r_hdr_pos;
        n_write_pos   = r_write_pos;
        n_age         = r_age;
        n_issue_idx   = r_issue_idx;
        n_data_pos    = r_data_pos;
        n_rd_pend     = r_rd_pend;
        mem_req.we    = 1'b0;
        mem_req.waddr = r_write_pos[STORE_AW-1:0];
        mem_req.wdata = i_rx_byte;
        mem_req.re    = issue;
        mem_req.raddr = r_issue_idx[STORE_AW-1:0];

        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_has   = r_out_has;
        n_out_pos   = r_out_pos;
        n_out_char  = r_out_char;
        n_out_len   = r_out_len;
        n_out_age   = r_out_age;
        n_out_last  = r_out_last;

        case (r_state)
            ST_WAIT: begin
                if (in_take && is_start) begin
                    n_hdr_pos = 3'd1;
                    if (i_rx_byte == CH_N) begin
                        n_kind = KIND_NAME;
                    end else if (i_rx_byte == CH_A) begin
                        n_kind = KIND_AGE;
                    end else begin
                        n_kind = KIND_SEX;
                    end
                end
            end
            ST_HEADER: begin
                if (in_take && hdr_match) begin
                    n_hdr_pos = 3'(r_hdr_pos + 3'd1);
                    if (hdr_done) begin
                        n_write_pos = '0;
                        if (r_kind == KIND_AGE) begin
                            n_age = 8'h00;
                        end
                    end
                end
            end
            ST_TEXT: begin
                if (in_take && (i_rx_byte != CH_CR)) begin
                    if (r_kind == KIND_AGE) begin
                        if (is_digit) begin
                            n_age = age_next;
                        end
                    end else if (r_write_pos < cap) begin
                        mem_req.we  = 1'b1;
                        n_write_pos = CNT_W'(r_write_pos + CNT_W'(1));
                    end
                end
            end
            ST_EOL: begin
                if (in_take && (i_rx_byte == CH_LF)) begin
                    n_issue_idx = '0;
                    n_rd_pend   = 1'b0;
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    n_issue_idx = CNT_W'(r_issue_idx + CNT_W'(1));
                    n_data_pos  = r_issue_idx[STORE_AW-1:0];
                    n_rd_pend   = 1'b1;
                end else if (load) begin
                    n_rd_pend   = 1'b0;
                end
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    if (single) begin
                        n_out_has  = 1'b0;
                        n_out_pos  = 4'd0;
                        n_out_char = 8'h00;
                        n_out_len  = 4'd0;
                        n_out_age  = (r_kind == KIND_AGE) ? r_age : 8'h00;
                        n_out_last = 1'b1;
                    end else begin
                        n_out_has  = 1'b1;
                        n_out_pos  = 4'(r_data_pos);
                        n_out_char = mem_rdata;
                        n_out_len  = 4'(r_write_pos);
                        n_out_age  = 8'h00;
                        n_out_last = data_last;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_kind      <= KIND_NAME;
            r_hdr_pos   <= 3'd0;
            r_write_pos <= '0;
            r_age       <= 8'h00;
            r_issue_idx <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_hdr_pos   <= n_hdr_pos;
            r_write_pos <= n_write_pos;
            r_age       <= n_age;
            r_issue_idx <= n_issue_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_pos <= n_data_pos;
        r_out_kind <= n_out_kind;
        r_out_has  <= n_out_has;
        r_out_pos  <= n_out_pos;
        r_out_char <= n_out_char;
        r_out_len  <= n_out_len;
        r_out_age  <= n_out_age;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_record_kind = r_out_kind;
    assign o_has_char    = r_out_has;
    assign o_char_pos    = r_out_pos;
    assign o_char_value  = r_out_char;
    assign o_text_length = r_out_len;
    assign o_age_value   = r_out_age;
    assign o_last        = r_out_last;

endmodule

// ===== design/tagrp_checker.sv =====
// Port-level checks for the tagged record parser, bound to the top level.
module tagrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_record_kind,
    input logic       o_has_char,
    input logic [3:0] o_char_pos,
    input logic [7:0] o_char_value,
    input logic [3:0] o_text_length,
    input logic [7:0] o_age_value,
    input logic       o_last
);
    import tagrp_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_char_value)
            && $stable(o_char_pos) && $stable(o_last))
        else $error("stalled result changed");

    // A record without text is always a single, final, empty result.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_char |-> o_last && (o_char_pos == 4'd0)
            && (o_char_value == 8'h00) && (o_text_length == 4'd0))
        else $error("empty record result malformed");

    // Text positions lie inside the record, and the final one closes it.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_char |-> (o_char_pos < o_text_length)
            && (o_last == ((o_char_pos + 4'd1) == o_text_length)))
        else $error("text position out of range");

    // Only age records carry an age value, and they carry no text.
    a_age_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_age_value != 8'h00) |-> (o_record_kind == KIND_AGE) && !o_has_char)
        else $error("age value on a non-age result");

endmodule

bind tagged_record_serial_parser_unit tagrp_checker u_tagrp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the tagged record serial parser unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tagrp_pkg::*;

    localparam int NAME_ROOM    = (NAME_CAPACITY_DEF > STORE_DEPTH) ? STORE_DEPTH
                                                                      : NAME_CAPACITY_DEF;
    localparam int SEX_ROOM     = (SEX_CAPACITY_DEF > STORE_DEPTH) ? STORE_DEPTH
                                                                     : SEX_CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 365;
    localparam int N_DIRECTED   = 29;

    typedef struct packed {
        t_kind      kind;
        logic       has_char;
        logic [3:0] pos;
        logic [7:0] value;
        logic [3:0] length;
        logic [7:0] age;
        logic       last;
    } t_rec_result;

    // One directed byte; where known is set, the row carries the single result of
    // the record that its line feed closes.
    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        t_kind      kind;
        logic [7:0] age;
    } t_line_step;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_record_kind;
    logic       o_has_char;
    logic [3:0] o_char_pos;
    logic [7:0] o_char_value;
    logic [3:0] o_text_length;
    logic [7:0] o_age_value;
    logic       o_last;

    t_line_step directed_steps [N_DIRECTED] = '{
        '{"N", 1'b0, KIND_NAME, 8'd0},
        '{"A", 1'b0, KIND_NAME, 8'd0},
        '{"X", 1'b0, KIND_NAME, 8'd0},
        '{"A", 1'b0, KIND_NAME, 8'd0},
        '{"G", 1'b0, KIND_NAME, 8'd0},
        '{"E", 1'b0, KIND_NAME, 8'd0},
        '{":", 1'b0, KIND_NAME, 8'd0},
        '{"2", 1'b0, KIND_NAME, 8'd0},
        '{"a", 1'b0, KIND_NAME, 8'd0},
        '{"5", 1'b0, KIND_NAME, 8'd0},
        '{"5", 1'b0, KIND_NAME, 8'd0},
        '{CH_CR, 1'b0, KIND_NAME, 8'd0},
        '{CH_LF, 1'b1, KIND_AGE, 8'd255},
        '{"S", 1'b0, KIND_NAME, 8'd0},
        '{"E", 1'b0, KIND_NAME, 8'd0},
        '{"X", 1'b0, KIND_NAME, 8'd0},
        '{":", 1'b0, KIND_NAME, 8'd0},
        '{8'h00, 1'b0, KIND_NAME, 8'd0},
        '{8'hFF, 1'b0, KIND_NAME, 8'd0},
        '{CH_LF, 1'b0, KIND_NAME, 8'd0},
        '{CH_CR, 1'b0, KIND_NAME, 8'd0},
        '{CH_LF, 1'b0, KIND_NAME, 8'd0},
        '{"N", 1'b0, KIND_NAME, 8'd0},
        '{"A", 1'b0, KIND_NAME, 8'd0},
        '{"M", 1'b0, KIND_NAME, 8'd0},
        '{"E", 1'b0, KIND_NAME, 8'd0},
        '{":", 1'b0, KIND_NAME, 8'd0},
        '{CH_CR, 1'b0, KIND_NAME, 8'd0},
        '{CH_LF, 1'b1, KIND_NAME, 8'd0}
    };

    // Parser state as the testbench tracks it.
    t_state      track_phase   = ST_WAIT;
    t_kind       track_kind    = KIND_NAME;
    int          track_hdr_pos = 0;
    int          track_len     = 0;
    logic [7:0]  track_age     = 8'd0;
    logic [7:0]  track_text [STORE_DEPTH];

    t_rec_result line_results [$];
    t_rec_result record_out_due [$];
    int          bad_results     = 0;
    int          rand_items_sent = 0;
    int          send_calm       = 0;
    int          take_calm       = 0;

    tagged_record_serial_parser_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_record_kind (o_record_kind),
        .o_has_char    (o_has_char),
        .o_char_pos    (o_char_pos),
        .o_char_value  (o_char_value),
        .o_text_length (o_text_length),
        .o_age_value   (o_age_value),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic string header_text(t_kind kind);
        case (kind)
            KIND_NAME: return "NAME:";
            KIND_AGE:  return "AGE:";
            KIND_SEX:  return "SEX:";
            default:   return "";
        endcase
    endfunction

    // Idle cycles before the next item, with occasional stretches of none.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Advances the tracked parser by one byte; a closing line feed leaves the
    // record's results in line_results.
    function automatic void parse_rx_byte(input logic [7:0] b);
        string       hdr;
        int          room;
        t_rec_result r;
        case (track_phase)
            ST_HEADER: begin
                hdr = header_text(track_kind);
                if (track_hdr_pos >= hdr.len() || b != hdr[track_hdr_pos]) begin
                    track_phase = ST_WAIT;
                end else begin
                    track_hdr_pos++;
                    if (track_hdr_pos >= hdr.len()) begin
                        track_phase = ST_TEXT;
                        track_len   = 0;
                        if (track_kind == KIND_AGE)
                            track_age = 8'd0;
                    end
                end
            end
            ST_TEXT: begin
                if (b == CH_CR) begin
                    track_phase = ST_EOL;
                end else if (track_kind == KIND_AGE) begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                        track_age = 8'(track_age * 8'd10 + (b - CH_ZERO));
                end else if (track_kind == KIND_NAME || track_kind == KIND_SEX) begin
                    room = (track_kind == KIND_NAME) ? NAME_ROOM : SEX_ROOM;
                    if (track_len < room) begin
                        track_text[track_len] = b;
                        track_len++;
                    end
                end
            end
            ST_EOL: begin
                if (b == CH_LF) begin
                    track_phase = ST_WAIT;
                    if (track_kind == KIND_AGE || track_len == 0) begin
                        r      = '0;
                        r.kind = track_kind;
                        r.age  = (track_kind == KIND_AGE) ? track_age : 8'd0;
                        r.last = 1'b1;
                        line_results.push_back(r);
                    end else begin
                        for (int k = 0; k < track_len; k++) begin
                            r          = '0;
                            r.kind     = track_kind;
                            r.has_char = 1'b1;
                            r.pos      = 4'(k);
                            r.value    = track_text[k];
                            r.length   = 4'(track_len);
                            r.last     = (k == track_len - 1);
                            line_results.push_back(r);
                        end
                    end
                end
            end
            default: begin
                track_phase = ST_WAIT;
                if (b == CH_N || b == CH_A || b == CH_S) begin
                    track_kind    = (b == CH_N) ? KIND_NAME : (b == CH_A) ? KIND_AGE
                                                                          : KIND_SEX;
                    track_hdr_pos = 1;
                    track_phase   = ST_HEADER;
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic known, input t_kind kind,
                             input logic [7:0] age);
        int          gap;
        t_rec_result r;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        parse_rx_byte(b);
        if (known) begin
            r      = '0;
            r.kind = kind;
            r.age  = age;
            r.last = 1'b1;
            line_results.delete();
            line_results.push_back(r);
        end
        foreach (line_results[i])
            record_out_due.push_back(line_results[i]);
        line_results.delete();
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_byte(b, 1'b0, KIND_NAME, 8'd0);
    endtask

    // A well-formed record with random content most of the time; now and then the
    // header breaks off or the terminator is missing.
    task automatic send_random_record();
        t_kind      kind;
        string      hdr;
        int         broken_at;
        int         n_text;
        logic [7:0] b;
        kind      = t_kind'($urandom_range(0, 2));
        hdr       = header_text(kind);
        broken_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, hdr.len() - 1) : -1;
        for (int i = 0; i < hdr.len(); i++) begin
            if (i == broken_at) begin
                b = 8'($urandom_range(0, 255));
                if (b == hdr[i])
                    b = b ^ 8'h01;
                send_rx(b);
                rand_items_sent++;
                return;
            end
            send_rx(hdr[i]);
            rand_items_sent++;
        end
        n_text = (kind == KIND_AGE) ? $urandom_range(0, 6) : $urandom_range(0, 12);
        for (int i = 0; i < n_text; i++) begin
            if (kind == KIND_AGE && $urandom_range(0, 3) != 0)
                b = 8'(CH_ZERO + $urandom_range(0, 9));
            else
                b = 8'($urandom_range(0, 255));
            if (b == CH_CR)
                b = CH_LF;
            send_rx(b);
            rand_items_sent++;
        end
        if ($urandom_range(0, 11) == 0)
            return;
        send_rx(CH_CR);
        rand_items_sent++;
        repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF)
                b = CH_N;
            send_rx(b);
            rand_items_sent++;
        end
        send_rx(CH_LF);
        rand_items_sent++;
    endtask

    task automatic check_record_result();
        t_rec_result want;
        if (record_out_due.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
                $display({"unexpected result: kind %0d has_char %0d pos %0d char %h",
                          " len %0d age %0d last %0d"},
                         o_record_kind, o_has_char, o_char_pos, o_char_value, o_text_length,
                         o_age_value, o_last);
            return;
        end
        want = record_out_due.pop_front();
        if (o_record_kind !== want.kind || o_has_char !== want.has_char ||
            o_char_pos !== want.pos || o_char_value !== want.value ||
            o_text_length !== want.length || o_age_value !== want.age ||
            o_last !== want.last) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("result mismatch at %0t", $realtime);
                $display({"  expected kind %0d has_char %0d pos %0d char %h",
                          " len %0d age %0d last %0d"},
                         want.kind, want.has_char, want.pos, want.value, want.length,
                         want.age, want.last);
                $display({"  actual   kind %0d has_char %0d pos %0d char %h",
                          " len %0d age %0d last %0d"},
                         o_record_kind, o_has_char, o_char_pos, o_char_value, o_text_length,
                         o_age_value, o_last);
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed_steps[i].rx, directed_steps[i].known, directed_steps[i].kind,
                      directed_steps[i].age);
        while (rand_items_sent < RANDOM_ITEMS) begin
            // Noise between records is not counted, and the tracked parser sees it like any other byte.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(0, 255)));
            send_random_record();
        end
        i_in_valid <= 1'b0;
        while (record_out_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (bad_results == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin : result_sink
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(take_calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            check_record_result();
        end
    end

    initial begin : run_limit
        #1_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tagrp_pkg.sv
design/tagrp_text_mem.sv
design/tagged_record_serial_parser_unit.sv
design/tagrp_checker.sv
tb/testbench.sv
